### rtl/core/mbss_pkg.sv
// Shared types and constants for the masked byte signature scanner.
// No dependencies; the cell, region and top-level RTL files import this package.
`default_nettype none

package mbss_pkg;

  localparam int PatternBytes = 16;
  localparam int OutOffsetW   = 32;
  localparam int CfgIndexW    = 2;
  localparam int CfgDataW     = 64;

  typedef logic [7:0] byte_t;
  typedef byte_t [PatternBytes-1:0] pattern_t;
  typedef logic [PatternBytes-1:0] mask_t;
  typedef logic [4:0] len_t;
  typedef logic [1:0] tally_t;

  typedef enum logic [CfgIndexW-1:0] {
    CfgPatLow  = 2'd0,
    CfgPatHigh = 2'd1,
    CfgMask    = 2'd2,
    CfgLength  = 2'd3
  } cfg_index_e;

  localparam tally_t TallyNone = 2'd0;
  localparam tally_t TallyOne  = 2'd1;
  localparam tally_t TallyMany = 2'd2;

  // One scan step handed from the cell row to the region tracker.
  typedef struct packed {
    logic take;
    logic last;
    logic cells_ok;
    len_t len;
  } step_t;

endpackage

`default_nettype wire

### rtl/core/mbss_if.sv
// Handshake interfaces for the scanner: input byte stream, result stream and
// configuration writes. Widths follow the fixed field widths of mbss_pkg.
`default_nettype none

interface mbss_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;
  modport source (output valid, data_byte, last_byte, input ready);
  modport sink   (input valid, data_byte, last_byte, output ready);
endinterface

interface mbss_out_if;
  logic        valid;
  logic        ready;
  logic        window_match;
  logic [31:0] match_start;
  logic        region_done;
  logic [1:0]  match_tally;
  logic [31:0] first_match_start;
  modport source (output valid, window_match, match_start, region_done, match_tally,
                  first_match_start, input ready);
  modport sink   (input valid, window_match, match_start, region_done, match_tally,
                  first_match_start, output ready);
endinterface

interface mbss_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [63:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

### rtl/core/mbss_cell.sv
// One window cell: holds one byte of the window and compares the byte it is
// about to take against the pattern byte that lines up with it. Uses mbss_pkg.
`default_nettype none

module mbss_cell #(
  parameter int IDX = 0
) (
  input  wire                clk_i,
  input  wire                shift_i,
  input  mbss_pkg::byte_t    byte_i,
  input  mbss_pkg::pattern_t pattern_i,
  input  mbss_pkg::mask_t    mask_i,
  input  mbss_pkg::len_t     len_i,
  output mbss_pkg::byte_t    byte_o,
  output logic               ok_o
);
  import mbss_pkg::*;

  byte_t      byte_q;
  logic [6:0] pos_full;
  logic [3:0] pos;
  logic       care;

  // Cell IDX sees pattern byte len-1-IDX; cells past the length are idle.
  assign care     = 7'(IDX) < {2'b00, len_i};
  assign pos_full = {2'b00, len_i} - 7'(IDX) - 7'd1;
  assign pos      = pos_full[3:0];
  assign ok_o     = !(care && mask_i[pos]) || (byte_i == pattern_i[pos]);
  assign byte_o   = byte_q;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      byte_q <= byte_i;
    end
  end

endmodule

`default_nettype wire

### rtl/core/mbss_region.sv
// Region tracker: byte offset, match tally, first match offset and the output
// register of the result stream. Uses mbss_pkg and mbss_out_if.
`default_nettype none

module mbss_region #(
  parameter int OFFSET_BITS = 32
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  mbss_pkg::step_t  step_i,
  output logic             room_o,
  mbss_out_if.source       out_o
);
  import mbss_pkg::*;

  localparam int ExtW = (OFFSET_BITS > OutOffsetW) ? OFFSET_BITS : OutOffsetW;
  localparam logic [OFFSET_BITS-1:0] OffMax = '1;

  logic [OFFSET_BITS-1:0] pos_q, pos_d;
  tally_t                 seen_q, seen_d;
  logic [OFFSET_BITS-1:0] first_q, first_d;
  logic [OFFSET_BITS-1:0] start;
  logic [OFFSET_BITS-1:0] len_m1;
  logic [ExtW-1:0]        start_ext, first_ext;
  logic                   hit;

  logic                   valid_q;
  logic                   match_q;
  logic [OutOffsetW-1:0]  start_q;
  logic                   done_q;
  tally_t                 tally_q;
  logic [OutOffsetW-1:0]  first_out_q;

  assign len_m1 = OFFSET_BITS'(step_i.len - 5'd1);
  assign hit    = step_i.cells_ok && (step_i.len != 5'd0) && (pos_q >= len_m1);

  always_comb begin
    start = '0;
    if (hit) begin
      start = (pos_q == OffMax) ? OffMax : pos_q - len_m1;
    end
  end

  always_comb begin
    seen_d  = seen_q;
    first_d = first_q;
    if (hit) begin
      if (seen_q == TallyNone) begin
        first_d = start;
      end
      if (seen_q != TallyMany) begin
        seen_d = seen_q + 2'd1;
      end
    end
    pos_d = (pos_q == OffMax) ? pos_q : pos_q + 1'b1;
  end

  assign start_ext = ExtW'(start);
  assign first_ext = ExtW'(first_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      seen_q  <= TallyNone;
      first_q <= '0;
    end else if (step_i.take) begin
      if (step_i.last) begin
        pos_q   <= '0;
        seen_q  <= TallyNone;
        first_q <= '0;
      end else begin
        pos_q   <= pos_d;
        seen_q  <= seen_d;
        first_q <= first_d;
      end
    end
  end

  // Take a new byte whenever the output register is empty or draining.
  assign room_o = !valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (step_i.take) begin
      valid_q <= 1'b1;
    end else if (out_o.ready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i.take) begin
      match_q     <= hit;
      start_q     <= start_ext[OutOffsetW-1:0];
      done_q      <= step_i.last;
      tally_q     <= step_i.last ? seen_d : TallyNone;
      first_out_q <= (step_i.last && seen_d != TallyNone) ? first_ext[OutOffsetW-1:0] : '0;
    end
  end

  assign out_o.valid             = valid_q;
  assign out_o.window_match      = match_q;
  assign out_o.match_start       = start_q;
  assign out_o.region_done       = done_q;
  assign out_o.match_tally       = tally_q;
  assign out_o.first_match_start = first_out_q;

  a_tally_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seen_q != 2'd3)
    else $error("match tally left its range");

  a_region_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i.take && step_i.last |=> pos_q == '0 && seen_q == TallyNone && first_q == '0)
    else $error("region state not cleared after last word");

  a_pos_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i.take && !step_i.last && pos_q != OffMax |=> pos_q == $past(pos_q) + 1'b1)
    else $error("byte offset did not advance");

  a_tally_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && done_q && tally_q == TallyNone |-> first_out_q == '0)
    else $error("first offset reported for a region without matches");

endmodule

`default_nettype wire

### rtl/core/masked_byte_signature_scanner.sv
// Masked byte signature scanner: takes one byte per clock while the output
// register has room and returns one result word per byte, registered in the
// cycle after the byte is accepted. The rate is one byte a cycle unless the full
// output register is not read; the row of PATTERN_MAX window cells each compare
// their incoming byte with the pattern in the same cycle the row shifts, and the
// region tracker and output register follow in that same cycle.
// There is no clearing pass after reset. Configuration registers are taken
// one per cycle and should be written only while the scanner is idle.
`default_nettype none

module masked_byte_signature_scanner #(
  parameter int PATTERN_MAX = 16,
  parameter int OFFSET_BITS = 32
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  mbss_cfg_if.sink    cfg_i,
  mbss_in_if.sink     in_i,
  mbss_out_if.source  out_o
);
  import mbss_pkg::*;

  localparam int LenCap = (PATTERN_MAX < PatternBytes) ? PATTERN_MAX : PatternBytes;

  logic [63:0] pat_low_q;
  logic [63:0] pat_high_q;
  mask_t       mask_q;
  len_t        len_q;
  len_t        len_eff;
  pattern_t    pattern;
  cfg_index_e  cfg_index;

  byte_t                  win [PATTERN_MAX];
  logic [PATTERN_MAX-1:0] ok;
  logic                   room;
  step_t                  step;

  assign cfg_i.ready = 1'b1;
  assign cfg_index   = cfg_index_e'(cfg_i.index);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_low_q  <= '0;
      pat_high_q <= '0;
      mask_q     <= '0;
      len_q      <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_index)
        CfgPatLow:  pat_low_q  <= cfg_i.data;
        CfgPatHigh: pat_high_q <= cfg_i.data;
        CfgMask:    mask_q     <= cfg_i.data[PatternBytes-1:0];
        CfgLength:  len_q      <= cfg_i.data[4:0];
        default: ;
      endcase
    end
  end

  assign pattern = pattern_t'({pat_high_q, pat_low_q});
  assign len_eff = (len_q > 5'(LenCap)) ? 5'(LenCap) : len_q;

  assign in_i.ready = room;

  for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
    byte_t cell_in;
    if (k == 0) begin : g_head
      assign cell_in = in_i.data_byte;
    end else begin : g_body
      assign cell_in = win[k-1];
    end
    mbss_cell #(
      .IDX (k)
    ) u_cell (
      .clk_i     (clk_i),
      .shift_i   (step.take),
      .byte_i    (cell_in),
      .pattern_i (pattern),
      .mask_i    (mask_q),
      .len_i     (len_eff),
      .byte_o    (win[k]),
      .ok_o      (ok[k])
    );
  end

  assign step.take     = in_i.valid && room;
  assign step.last     = in_i.last_byte;
  assign step.cells_ok = &ok;
  assign step.len      = len_eff;

  mbss_region #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_region (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .room_o (room),
    .out_o  (out_o)
  );

endmodule

`default_nettype wire
